FILE: rtl/iak_pkg.sv
// Package for the interval admission block: payload types, controller command and
// status structs, and the field widths and limits shared by the datapath and the testbench.
// Depends on nothing; the other modules and the testbench refer to it by scoped names.
`default_nettype none

package iak_pkg;

   // Field widths of the request, response and configuration payloads.
   localparam int TIME_W  = 32;
   localparam int LIMIT_W = 7;
   localparam int BUSY_W  = 7;
   localparam int TOTAL_W = 24;

   // Default number of server slots.
   localparam int MAX_SERVERS_DEF = 64;

   // Reset value of the server limit and the saturation points of the outputs.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd1;
   localparam logic [BUSY_W-1:0]  BUSY_MAX    = 7'd127;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 24'hFF_FFFF;

   typedef struct packed {
      logic [TIME_W-1:0] arrival_time;
      logic [TIME_W-1:0] departure_time;
      logic              first_of_run;
   } req_payload_type;

   typedef struct packed {
      logic               admitted;
      logic [BUSY_W-1:0]  busy_after;
      logic [TOTAL_W-1:0] admitted_total;
   } rsp_payload_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] server_limit;
   } csr_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic addr_clear;
      logic addr_step;
      logic clear_wr;
      logic read;
      logic load;
      logic commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic addr_last;
      logic rd_live;
      logic rsp_hold;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/iak_chan_if.sv
// Valid/ready channel interface used for the request, response and configuration ports.
// The payload type is a parameter; the types themselves come from iak_pkg.
`default_nettype none

interface iak_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/iak_datapath.sv
// Datapath of the interval admission block: slot memory, scan pipeline, busy count,
// admit decision, admitted total, server limit register and response register.
// Depends on iak_pkg for payload, command and status types.
`default_nettype none

module iak_datapath #(
   parameter int MAX_SERVERS = iak_pkg::MAX_SERVERS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  iak_pkg::req_payload_type      req_payload,
   input  wire                           csr_write,
   input  wire [iak_pkg::LIMIT_W-1:0]    csr_limit,
   input  iak_pkg::dp_cmd_type           cmd,
   output iak_pkg::dp_status_type        status,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output iak_pkg::rsp_payload_type      rsp_payload
);

   localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int BW = $clog2(MAX_SERVERS + 1);
   localparam int CW = (BW > iak_pkg::LIMIT_W) ? BW : iak_pkg::LIMIT_W;
   localparam int WW = iak_pkg::TIME_W + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SERVERS - 1);

   // Each memory word holds a valid flag above the stored departure time.
   logic [WW-1:0] slot_mem [MAX_SERVERS];

   logic [iak_pkg::LIMIT_W-1:0]  limit_ff;
   logic [AW-1:0]                addr_ff, addr_in;
   logic [WW-1:0]                rd_word_ff;
   logic [AW-1:0]                rd_idx_ff;
   logic                         rd_live_ff;
   logic [iak_pkg::TIME_W-1:0]   arr_ff, dep_ff;
   logic                         first_ff;
   logic [BW-1:0]                busy_ff, busy_in;
   logic                         found_ff, found_in;
   logic [AW-1:0]                free_idx_ff, free_idx_in;
   logic [iak_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic                         rsp_valid_ff;
   iak_pkg::rsp_payload_type     rsp_ff;

   logic                         rd_valid;
   logic [iak_pkg::TIME_W-1:0]   rd_end;
   logic                         keep_slot;
   logic                         drop_slot;
   logic [CW-1:0]                busy_c, lim_c, cap_c, eff_c, after_c;
   logic                         admit;
   logic [iak_pkg::BUSY_W-1:0]   busy_out;
   logic [iak_pkg::TOTAL_W-1:0]  total_base;

   // Server limit register, written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= iak_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         limit_ff <= csr_limit;
      end
   end

   // Slot address counter shared by the clearing pass and the scan.
   always_comb begin
      addr_in = addr_ff;
      if (cmd.addr_clear) begin
         addr_in = '0;
      end else if (cmd.addr_step) begin
         addr_in = addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else begin
         addr_ff <= addr_in;
      end
   end

   // A slot read last cycle stays busy only if it is valid, the run continues
   // and its departure lies after the new arrival.
   assign rd_valid  = rd_word_ff[iak_pkg::TIME_W];
   assign rd_end    = rd_word_ff[iak_pkg::TIME_W-1:0];
   assign keep_slot = rd_valid && !first_ff && (rd_end > arr_ff);
   assign drop_slot = rd_live_ff && rd_valid && !keep_slot;

   // Admit decision against the limit, capped at the number of slots.
   always_comb begin
      busy_c     = CW'(busy_ff);
      lim_c      = CW'(limit_ff);
      cap_c      = CW'(MAX_SERVERS);
      eff_c      = (lim_c > cap_c) ? cap_c : lim_c;
      admit      = busy_c < eff_c;
      after_c    = busy_c + CW'(admit);
      busy_out   = (after_c > CW'(iak_pkg::BUSY_MAX)) ? iak_pkg::BUSY_MAX
                                                       : after_c[iak_pkg::BUSY_W-1:0];
      total_base = first_ff ? '0 : total_ff;
      total_in   = (admit && (total_base != iak_pkg::TOTAL_MAX))
                   ? total_base + iak_pkg::TOTAL_W'(1) : total_base;
   end

   // Slot memory: one write port (clearing, freeing or admitting) and one read port.
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         slot_mem[addr_ff] <= '0;
      end else if (drop_slot) begin
         slot_mem[rd_idx_ff] <= '0;
      end else if (cmd.commit && admit) begin
         slot_mem[free_idx_ff] <= {1'b1, dep_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_word_ff <= slot_mem[addr_ff];
         rd_idx_ff  <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_live_ff <= 1'b0;
      end else begin
         rd_live_ff <= cmd.read;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         arr_ff   <= req_payload.arrival_time;
         dep_ff   <= req_payload.departure_time;
         first_ff <= req_payload.first_of_run;
      end
   end

   // Busy count and lowest free slot, gathered one slot per cycle.
   always_comb begin
      busy_in     = busy_ff;
      found_in    = found_ff;
      free_idx_in = free_idx_ff;
      if (cmd.load) begin
         busy_in  = '0;
         found_in = 1'b0;
      end else if (rd_live_ff) begin
         if (keep_slot) begin
            busy_in = busy_ff + BW'(1);
         end else if (!found_ff) begin
            found_in    = 1'b1;
            free_idx_in = rd_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      busy_ff     <= busy_in;
      found_ff    <= found_in;
      free_idx_ff <= free_idx_in;
   end

   // Admitted total of the run.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (cmd.commit) begin
         total_ff <= total_in;
      end
   end

   // Response register: holds one result until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.admitted       <= admit;
         rsp_ff.busy_after     <= busy_out;
         rsp_ff.admitted_total <= total_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign status.addr_last = (addr_ff == LAST_ADDR);
   assign status.rd_live   = rd_live_ff;
   assign status.rsp_hold  = rsp_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

FILE: rtl/iak_controller.sv
// Controller of the interval admission block: clearing pass after reset, request
// intake, slot scan and decision, issuing commands to iak_datapath.
// Depends on iak_pkg for the command and status structs.
`default_nettype none

module iak_controller (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  iak_pkg::dp_status_type   status,
   output iak_pkg::dp_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.addr_last) begin
               cmd.addr_clear = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.addr_step = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.read = 1'b1;
            if (status.addr_last) begin
               cmd.addr_clear = 1'b1;
               state_in       = ST_DRAIN;
            end else begin
               cmd.addr_step = 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!status.rsp_hold) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/interval_admission_k_servers.sv
// Top level of the interval admission block for k servers.
// Depends on iak_pkg, iak_chan_if, iak_controller and iak_datapath.
//
//   Channel   Modport  Payload             Direction
//   req_chan  sink     req_payload_type    request intervals in
//   rsp_chan  source   rsp_payload_type    admit results out
//   csr_chan  sink     csr_payload_type    server_limit writes in
//
// Each request is handled by a scan that reads the slot memory one slot per cycle through
// its single port; no new request is taken until the decision for the previous one is made.
// After reset a clearing pass empties the slot memory; no request is taken meanwhile, but
// configuration writes are. Reset is synchronous and active high.
// The result sits in an output register; a stalled sink holds the next decision only.
`default_nettype none

module interval_admission_k_servers #(
   parameter int MAX_SERVERS = iak_pkg::MAX_SERVERS_DEF
) (
   input wire         clock,
   input wire         reset,
   iak_chan_if.sink   req_chan,
   iak_chan_if.source rsp_chan,
   iak_chan_if.sink   csr_chan
);

   iak_pkg::dp_cmd_type    cmd;
   iak_pkg::dp_status_type status;
   iak_pkg::rsp_payload_type rsp_payload;
   logic                   rsp_valid;
   logic                   req_ready;

   // The limit register takes a write in any cycle.
   assign csr_chan.ready = 1'b1;

   iak_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   iak_datapath #(
      .MAX_SERVERS (MAX_SERVERS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_chan.payload),
      .csr_write   (csr_chan.valid),
      .csr_limit   (csr_chan.payload.server_limit),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_payload)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

   // An accepted request starts the slot scan in the next cycle.
   a_scan_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> cmd.read)
      else $error("slot scan did not start after a request was accepted");

   // The decision is taken only after the last slot read has been evaluated.
   a_commit_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !status.rd_live)
      else $error("decision taken while a slot read was still pending");

   // The clearing write, decision commit, request capture and slot read commands never overlap.
   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_wr, cmd.commit, cmd.load, cmd.read}))
      else $error("conflicting datapath commands");

   // A new response appears only as the result of a decision.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.commit))
      else $error("response raised without a decision");

endmodule

`default_nettype wire

FILE: test/interval_admission_k_servers_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for interval_admission_k_servers: directed and random requests,
// server limit changes between phases, and a predictor that checks every admit decision.
// Depends on iak_pkg, iak_chan_if and the RTL of the block under test.

module interval_admission_k_servers_tb;

   localparam int SERVERS       = iak_pkg::MAX_SERVERS_DEF;
   localparam int RANDOM_TARGET = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   iak_chan_if #(.payload_type(iak_pkg::req_payload_type)) req_if ();
   iak_chan_if #(.payload_type(iak_pkg::rsp_payload_type)) rsp_if ();
   iak_chan_if #(.payload_type(iak_pkg::csr_payload_type)) csr_if ();

   interval_admission_k_servers #(.MAX_SERVERS(SERVERS)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Shadow copy of the block's slots, running total and server limit.
   logic [iak_pkg::TIME_W-1:0]  slot_departure [SERVERS];
   logic                        slot_occupied [SERVERS];
   logic [iak_pkg::TOTAL_W-1:0] admitted_so_far;
   logic [iak_pkg::LIMIT_W-1:0] server_limit_model;

   iak_pkg::rsp_payload_type expected_decisions [$];
   int  mismatch_count = 0;
   int  requests_sent = 0;
   bit  steady_flow = 1'b0;

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Every input of the block is known from time zero.
   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      rsp_if.ready   = 1'b0;
   end

   // Works out the admit decision for one request and updates the shadow state.
   function automatic iak_pkg::rsp_payload_type predict_admission(
      input iak_pkg::req_payload_type req);
      iak_pkg::rsp_payload_type decision;
      int unsigned     busy;
      int unsigned     capacity;
      int              free_idx;
      busy     = 0;
      free_idx = -1;
      if (req.first_of_run) begin
         foreach (slot_occupied[k]) slot_occupied[k] = 1'b0;
         admitted_so_far = '0;
      end
      capacity = (server_limit_model > SERVERS) ? SERVERS : server_limit_model;
      // A slot whose departure is not later than the arrival is released first.
      foreach (slot_occupied[k]) begin
         if (slot_occupied[k] && slot_departure[k] <= req.arrival_time)
            slot_occupied[k] = 1'b0;
         if (slot_occupied[k])
            busy++;
         else if (free_idx < 0)
            free_idx = k;
      end
      decision.admitted = 1'b0;
      if (busy < capacity && free_idx >= 0) begin
         slot_occupied[free_idx]  = 1'b1;
         slot_departure[free_idx] = req.departure_time;
         busy++;
         decision.admitted = 1'b1;
         if (admitted_so_far != iak_pkg::TOTAL_MAX)
            admitted_so_far++;
      end
      decision.busy_after     = (busy > iak_pkg::BUSY_MAX) ? iak_pkg::BUSY_MAX
                                                           : busy[iak_pkg::BUSY_W-1:0];
      decision.admitted_total = admitted_so_far;
      return decision;
   endfunction

   // Sends one request after a random gap (none in steady flow); valid stays high until the next call or a drain.
   task automatic send_request(input logic [iak_pkg::TIME_W-1:0] arrival,
                               input logic [iak_pkg::TIME_W-1:0] departure,
                               input logic first_flag);
      iak_pkg::req_payload_type req;
      int              gap;
      req.arrival_time   = arrival;
      req.departure_time = departure;
      req.first_of_run   = first_flag;
      gap = steady_flow ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= req;
      do @(posedge clock); while (!req_if.ready);
      expected_decisions.push_back(predict_admission(req));
      requests_sent++;
   endtask

   // Holds off the sender until every outstanding decision has come back.
   task automatic drain_decisions();
      req_if.valid <= 1'b0;
      while (expected_decisions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the server limit while the block is idle.
   task automatic write_server_limit(input logic [iak_pkg::LIMIT_W-1:0] limit);
      iak_pkg::csr_payload_type csr;
      csr.server_limit = limit;
      drain_decisions();
      csr_if.valid   <= 1'b1;
      csr_if.payload <= csr;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      server_limit_model = limit;
   endtask

   // One server from reset: departure equal to arrival, departure before arrival,
   // arrivals out of order, extreme times and a mid-run restart.
   task automatic test_reset_limit();
      send_request(32'd0, 32'd10, 1'b1);
      send_request(32'd5, 32'd20, 1'b0);
      send_request(32'd10, 32'd10, 1'b0);
      send_request(32'd10, 32'd3, 1'b0);
      send_request(32'd4, 32'd9, 1'b0);
      send_request(32'd2, 32'd100, 1'b0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_request(32'hFFFF_FFFE, 32'd0, 1'b1);
      send_request(32'd0, 32'hFFFF_FFFF, 1'b0);
   endtask

   // With no servers every request is rejected, restart or not.
   task automatic test_limit_zero();
      write_server_limit(7'd0);
      send_request(32'd50, 32'd60, 1'b0);
      send_request(32'd70, 32'd80, 1'b1);
      send_request(32'd0, 32'hFFFF_FFFF, 1'b0);
   endtask

   // Two servers: overlap, rejection when full, and release on equal times.
   task automatic test_two_servers();
      write_server_limit(7'd2);
      send_request(32'd100, 32'd200, 1'b1);
      send_request(32'd150, 32'd300, 1'b0);
      send_request(32'd160, 32'd170, 1'b0);
      send_request(32'd200, 32'd250, 1'b0);
      send_request(32'd300, 32'd301, 1'b0);
   endtask

   // Limits at and above the slot count: fill every slot, then overflow it.
   task automatic test_limit_above_capacity();
      logic [iak_pkg::TIME_W-1:0]  arrival;
      logic [iak_pkg::LIMIT_W-1:0] limits [3];
      limits = '{7'd127, 7'd65, 7'd64};
      foreach (limits[p]) begin
         write_server_limit(limits[p]);
         steady_flow = (p == 1);
         arrival = $urandom_range(0, 1000);
         for (int i = 0; i < SERVERS + 6; i++) begin
            send_request(arrival, arrival + 32'd100000 + $urandom_range(0, 1000), i == 0);
            arrival += $urandom_range(0, 1);
         end
      end
   endtask

   // One run of requests: mostly ordered intervals from a restart, sometimes pure noise.
   task automatic send_random_run();
      logic [iak_pkg::TIME_W-1:0] arrival;
      logic [iak_pkg::TIME_W-1:0] departure;
      int unsigned       step_max;
      int unsigned       hold_max;
      int unsigned       run_len;
      bit                noisy;
      if ($urandom_range(0, 5) == 0)
         drain_decisions();
      steady_flow = ($urandom_range(0, 3) == 0);
      noisy   = ($urandom_range(0, 7) == 0);
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 30);
      case ($urandom_range(0, 4))
         0: step_max = 0;
         1: step_max = 1;
         2: step_max = 3;
         3: step_max = 15;
         default: step_max = 255;
      endcase
      case ($urandom_range(0, 4))
         0: hold_max = 0;
         1: hold_max = 4;
         2: hold_max = 32;
         3: hold_max = 300;
         default: hold_max = 100000;
      endcase
      arrival = $urandom();
      for (int i = 0; i < run_len; i++) begin
         if (noisy) begin
            send_request($urandom(), $urandom(), $urandom_range(0, 9) == 0);
         end else begin
            // Now and then the departure does not come after the arrival.
            if ($urandom_range(0, 15) == 0)
               departure = arrival - $urandom_range(0, 3);
            else
               departure = arrival + $urandom_range(0, hold_max);
            send_request(arrival, departure, i == 0);
            arrival += $urandom_range(0, step_max);
         end
      end
   endtask

   // Random runs under a sequence of server limits, then random limits.
   task automatic test_random_runs();
      logic [iak_pkg::LIMIT_W-1:0] limit_plan [10];
      int                 phase;
      limit_plan = '{7'd1, 7'd2, 7'd3, 7'd7, 7'd16, 7'd63, 7'd64, 7'd0, 7'd65, 7'd5};
      phase = 0;
      while (requests_sent < RANDOM_TARGET) begin
         if (phase < 10)
            write_server_limit(limit_plan[phase]);
         else
            write_server_limit(iak_pkg::LIMIT_W'($urandom_range(0, 127)));
         phase++;
         repeat (8) send_random_run();
      end
   endtask

   // Result side: random stall before each result, none during steady stretches.
   initial begin : result_sink
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Compares each accepted result with the oldest expected decision.
   always @(posedge clock) begin : check_decision
      iak_pkg::rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_decisions.size() == 0) begin
            $display("%0t: unexpected result: admitted %0d busy_after %0d admitted_total %0d",
                     $time, rsp_if.payload.admitted, rsp_if.payload.busy_after,
                     rsp_if.payload.admitted_total);
            mismatch_count++;
         end else begin
            want = expected_decisions.pop_front();
            if (rsp_if.payload.admitted !== want.admitted) begin
               $display("%0t: admitted: expected %0d, actual %0d",
                        $time, want.admitted, rsp_if.payload.admitted);
               mismatch_count++;
            end
            if (rsp_if.payload.busy_after !== want.busy_after) begin
               $display("%0t: busy_after: expected %0d, actual %0d",
                        $time, want.busy_after, rsp_if.payload.busy_after);
               mismatch_count++;
            end
            if (rsp_if.payload.admitted_total !== want.admitted_total) begin
               $display("%0t: admitted_total: expected %0d, actual %0d",
                        $time, want.admitted_total, rsp_if.payload.admitted_total);
               mismatch_count++;
            end
         end
      end
   end

   // Test sequence.
   initial begin
      foreach (slot_occupied[k]) begin
         slot_occupied[k]  = 1'b0;
         slot_departure[k] = '0;
      end
      admitted_so_far    = '0;
      server_limit_model = iak_pkg::LIMIT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_limit();
      test_limit_zero();
      test_two_servers();
      test_limit_above_capacity();
      test_random_runs();

      // Let any stray result show up after the last expected one.
      drain_decisions();
      repeat (SERVERS + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog: reports a failure and stops a run that hangs.
   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/iak_pkg.sv
rtl/iak_chan_if.sv
rtl/iak_datapath.sv
rtl/iak_controller.sv
rtl/interval_admission_k_servers.sv
test/interval_admission_k_servers_tb.sv
